FILE: rtl/core/fwrl_pkg.sv
`timescale 1ns / 1ps

package fwrl_pkg;

  // hash and counter constants
  localparam logic [31:0] HASH_SEED    = 32'd5381;
  localparam logic [16:0] COUNT_MAX    = 17'h10000;
  localparam logic [15:0] WINDOW_RESET = 16'd60;

  // configuration register indexes
  localparam int          CFG_IDX_W          = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 1'b1;

  // one way of a bucket row
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [16:0] count;
    logic [31:0] start;
  } way_t;

  typedef enum logic [1:0] {
    OUT_EXISTING = 2'd0,
    OUT_NEW      = 2'd1,
    OUT_FULL     = 2'd2,
    OUT_DISABLED = 2'd3
  } outcome_t;

  typedef struct packed {
    logic        allowed;
    outcome_t    outcome;
    logic [16:0] count;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_UPDATE
  } state_t;

endpackage

FILE: rtl/core/fwrl_ram.sv
`timescale 1ns / 1ps

module fwrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/fwrl_hash.sv
`timescale 1ns / 1ps

module fwrl_hash #(
  parameter int BUCKETS = 1024
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [31:0]                                addr,
  output logic                                       done,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [BW:0] BUCKETS_EXT = (BW + 1)'(BUCKETS);

  logic          busy_r;
  logic          done_r;
  logic [2:0]    step_r;
  logic [31:0]   addr_r;
  logic [31:0]   h_r;
  logic [BW-1:0] rem_r;
  logic [31:0]   h_nxt;
  logic [BW-1:0] rem_nxt;

  // djb2 step: h*33 + byte
  assign h_nxt = h_r + {h_r[26:0], 5'd0} + {24'd0, addr_r[31:24]};

  // remainder of h by the bucket count, eight bits of h per cycle
  always_comb begin
    logic [BW:0] t;
    t = {1'b0, rem_r};
    for (int i = 7; i >= 0; i--) begin
      t = {t[BW-1:0], h_r[24 + i]};
      if (t >= BUCKETS_EXT) begin
        t = t - BUCKETS_EXT;
      end
    end
    rem_nxt = t[BW-1:0];
  end

  // sequencer: four hash steps, then four reduction steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      addr_r <= addr;
      h_r    <= fwrl_pkg::HASH_SEED;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (!step_r[2]) begin
        h_r    <= h_nxt;
        addr_r <= {addr_r[23:0], 8'd0};
      end else begin
        rem_r <= rem_nxt;
        h_r   <= {h_r[23:0], 8'd0};
      end
    end
  end

  assign done   = done_r;
  assign bucket = rem_r;

endmodule

FILE: rtl/core/fwrl_update.sv
`timescale 1ns / 1ps

module fwrl_update #(
  parameter int WAYS = 4
) (
  input  fwrl_pkg::way_t [WAYS-1:0] row,
  input  logic [31:0]               key,
  input  logic [31:0]               now,
  input  logic [15:0]               limit,
  input  logic [15:0]               window,
  output fwrl_pkg::way_t [WAYS-1:0] row_nxt,
  output logic                      row_we,
  output fwrl_pkg::result_t         res
);

  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic           hit;
  logic           have_free;
  logic [WW-1:0]  hit_idx;
  logic [WW-1:0]  free_idx;
  logic [WW-1:0]  sel_idx;
  fwrl_pkg::way_t cur;
  logic [31:0]    elapsed;

  // first matching way and first free way
  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    hit_idx   = '0;
    free_idx  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row[w].valid) begin
        if (!hit && row[w].key == key) begin
          hit     = 1'b1;
          hit_idx = WW'(w);
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_idx  = WW'(w);
      end
    end
  end

  assign sel_idx = hit ? hit_idx : free_idx;
  assign elapsed = now - (hit ? row[hit_idx].start : now);

  // window restart and saturating count on the selected way
  always_comb begin
    if (hit) begin
      cur = row[hit_idx];
    end else begin
      cur.valid = 1'b1;
      cur.key   = key;
      cur.count = '0;
      cur.start = now;
    end
    if (elapsed >= {16'd0, window}) begin
      cur.count = '0;
      cur.start = now;
    end
    if (cur.count != fwrl_pkg::COUNT_MAX) begin
      cur.count = cur.count + 17'd1;
    end
    row_nxt          = row;
    row_nxt[sel_idx] = cur;
  end

  // result and write decision
  always_comb begin
    if (limit == 16'd0) begin
      row_we      = 1'b0;
      res.allowed = 1'b1;
      res.outcome = fwrl_pkg::OUT_DISABLED;
      res.count   = '0;
    end else if (!hit && !have_free) begin
      row_we      = 1'b0;
      res.allowed = 1'b1;
      res.outcome = fwrl_pkg::OUT_FULL;
      res.count   = '0;
    end else begin
      row_we      = 1'b1;
      res.allowed = (cur.count <= {1'b0, limit});
      res.outcome = hit ? fwrl_pkg::OUT_EXISTING : fwrl_pkg::OUT_NEW;
      res.count   = cur.count;
    end
  end

endmodule

FILE: rtl/core/per_client_fixed_window_rate_limiter.sv
`timescale 1ns / 1ps

// channel   direction  beat contents
// in_       slave      tdata: client_address, now_seconds
// out_      master     tdata: allowed, outcome, request_count
// cfg_      write      index 0 request_limit, index 1 window_seconds
//
// the result beat is presented after the hash state (8 byte-serial hash and
// reduction steps, one row read) and one update and write-back; the next input
// beat is taken once the block is back in idle
// after reset a clearing pass writes all BUCKETS rows with in_tready low;
// configuration writes are taken during it
// a stalled result holds the item at write-back until the output register frees

module per_client_fixed_window_rate_limiter #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [63:0]                      in_tdata,   // client_address, now_seconds
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // allowed, outcome, request_count
  input  logic                             cfg_we,
  input  logic [fwrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_wdata
);

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int ROW_W = WAYS * $bits(fwrl_pkg::way_t);
  localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

  fwrl_pkg::state_t  state_r, state_nxt;
  logic [BW-1:0]     clr_addr_r;
  logic [31:0]       key_r;
  logic [31:0]       now_r;
  logic [BW-1:0]     bucket_r;
  logic [15:0]       limit_r;
  logic [15:0]       window_r;
  logic              out_valid_r;
  fwrl_pkg::result_t out_res_r;

  logic              hash_start;
  logic              hash_done;
  logic [BW-1:0]     hash_bucket;
  logic              out_free;
  logic              out_load;
  logic              ram_we;
  logic [BW-1:0]     ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ROW_W-1:0]  ram_rdata;

  fwrl_pkg::way_t [WAYS-1:0] rd_row;
  fwrl_pkg::way_t [WAYS-1:0] upd_row;
  logic                      upd_we;
  fwrl_pkg::result_t         upd_res;

  assign out_free = !out_valid_r || out_tready;
  assign rd_row   = ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= '0;
      window_r <= fwrl_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fwrl_pkg::CFG_REQUEST_LIMIT:  limit_r  <= cfg_wdata;
        fwrl_pkg::CFG_WINDOW_SECONDS: window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fwrl_pkg::ST_CLEAR:  if (clr_addr_r == LAST_ROW) state_nxt = fwrl_pkg::ST_IDLE;
      fwrl_pkg::ST_IDLE:   if (in_tvalid) state_nxt = fwrl_pkg::ST_HASH;
      fwrl_pkg::ST_HASH:   if (hash_done) state_nxt = fwrl_pkg::ST_UPDATE;
      fwrl_pkg::ST_UPDATE: if (out_free) state_nxt = fwrl_pkg::ST_IDLE;
      default:             state_nxt = fwrl_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = bucket_r;
    ram_wdata = upd_row;
    out_load  = 1'b0;
    case (state_r)
      fwrl_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      fwrl_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      fwrl_pkg::ST_HASH: begin
        ram_re = hash_done;
      end
      fwrl_pkg::ST_UPDATE: begin
        out_load = out_free;
        ram_we   = out_free && upd_we;
      end
      default: ;
    endcase
  end

  assign hash_start = in_tvalid && in_tready;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fwrl_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == fwrl_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + BW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (hash_start) begin
      key_r <= in_tdata[31:0];
      now_r <= in_tdata[63:32];
    end
    if (ram_re) begin
      bucket_r <= hash_bucket;
    end
    if (out_load) begin
      out_res_r <= upd_res;
    end
  end

  fwrl_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .addr   (in_tdata[31:0]),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  fwrl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (hash_bucket),
    .rdata (ram_rdata)
  );

  fwrl_update #(
    .WAYS (WAYS)
  ) u_update (
    .row     (rd_row),
    .key     (key_r),
    .now     (now_r),
    .limit   (limit_r),
    .window  (window_r),
    .row_nxt (upd_row),
    .row_we  (upd_we),
    .res     (upd_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.count, out_res_r.outcome, out_res_r.allowed};

endmodule
